@@ sv/stable_priority_queue_core_assert.svh @@
// Assertion macros for the queue RTL.
// SPQ_ASSERT is disabled while reset is held; SPQ_ASSERT_ALWAYS also checks during reset.
`ifndef STABLE_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ sv/spq_pkg.sv @@
package spq_pkg;

    // Default geometry of the queue.
    localparam int DEPTH_DEF  = 16;
    localparam int LEVELS_DEF = 3;

    // Fixed field widths.
    localparam int ID_W  = 32;
    localparam int CLS_W = 2;

    // Request operation codes.
    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_opcode;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_BADCLASS = 2'd3
    } t_status;

    // One stored queue entry.
    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [ID_W-1:0]  id;
    } t_entry;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry item;
    } t_cell_ctl;

endpackage

@@ sv/spq_req_if.sv @@
interface spq_req_if
    import spq_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [ID_W-1:0]  customer_id;
    logic [CLS_W-1:0] service_class;

    modport source (output valid, opcode, customer_id, service_class, input ready);
    modport sink (input valid, opcode, customer_id, service_class, output ready);
endinterface

@@ sv/spq_rsp_if.sv @@
interface spq_rsp_if
    import spq_pkg::*;
#(
    parameter int CNT_W = $clog2(DEPTH_DEF + 1)
) ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic             out_valid;
    logic [ID_W-1:0]  out_id;
    logic [CLS_W-1:0] out_class;
    logic [CNT_W-1:0] occupancy;

    modport source (output valid, status, out_valid, out_id, out_class, occupancy,
                     input ready);
    modport sink (input valid, status, out_valid, out_id, out_class, occupancy,
                   output ready);
endinterface

@@ sv/spq_cell.sv @@
module spq_cell
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int INDEX = 0,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0] i_cnt,
    input  logic             i_prev_keep,
    input  t_entry           i_prev_entry,
    input  t_entry           i_next_entry,
    output logic             o_keep,
    output t_entry           o_entry
);

    t_entry r_entry;
    t_entry n_entry;
    logic   occupied;

    // A slot is occupied when it lies below the fill count.
    assign occupied = CNT_W'(INDEX) < i_cnt;

    // The entry stays put if it ranks at or above the new item.
    assign o_keep  = occupied && (r_entry.cls >= i_ctl.item.cls);
    assign o_entry = r_entry;

    // Insert at the boundary, shift back behind it, or shift forward on a pop.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.enq && !o_keep) begin
            n_entry = i_prev_keep ? i_ctl.item : i_prev_entry;
        end else if (i_ctl.deq) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

@@ sv/stable_priority_queue_core.sv @@
// A request beat is answered by one response beat, registered and shown in the cycle after acceptance.
// Throughput: one request per cycle while no response stalls it; the whole cell chain shifts together.
// A new request enters only while no response waits or in the cycle its beat is taken.
// Reset (synchronous, active low) empties the queue and drops any pending response.
// Entry payloads are not reset; only slots below the fill count are ever read.
module stable_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int LEVELS = LEVELS_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spq_req_if.sink      i_req,
    spq_rsp_if.source    o_rsp
);

`include "stable_priority_queue_core_assert.svh"

    logic             r_out_vld;
    logic             n_out_vld;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    t_status          r_status;
    t_status          n_status;
    logic             r_ret;
    logic             n_ret;
    t_entry           r_ret_entry;
    t_entry           n_ret_entry;

    logic      accept;
    logic      is_deq;
    logic      cls_bad;
    logic      full;
    logic      empty;
    t_cell_ctl ctl;

    logic   keep  [DEPTH];
    t_entry entry [DEPTH];

    // Handshake: the response register frees up when its beat is taken.
    assign i_req.ready = i_rst_n && (!r_out_vld || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;

    // Request decode.
    assign is_deq  = i_req.opcode == OP_DEQ;
    assign cls_bad = 32'(i_req.service_class) >= 32'(LEVELS);
    assign full    = r_cnt == CNT_W'(DEPTH);
    assign empty   = r_cnt == '0;

    assign ctl.enq       = accept && !is_deq && !cls_bad && !full;
    assign ctl.deq       = accept && is_deq && !empty;
    assign ctl.item.cls  = i_req.service_class;
    assign ctl.item.id   = i_req.customer_id;

    // Chain of cells, slot zero at the front.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic   prev_keep;
        t_entry prev_entry;
        t_entry next_entry;

        if (g == 0) begin : g_head
            assign prev_keep  = 1'b1;
            assign prev_entry = ctl.item;
        end else begin : g_body
            assign prev_keep  = keep[g-1];
            assign prev_entry = entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign next_entry = entry[g];
        end else begin : g_link
            assign next_entry = entry[g+1];
        end

        spq_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_cnt        (r_cnt),
            .i_prev_keep  (prev_keep),
            .i_prev_entry (prev_entry),
            .i_next_entry (next_entry),
            .o_keep       (keep[g]),
            .o_entry      (entry[g])
        );
    end

    // Status, returned entry and next fill count.
    always_comb begin
        n_status    = r_status;
        n_ret       = r_ret;
        n_ret_entry = r_ret_entry;
        n_cnt       = r_cnt;
        n_out_vld   = r_out_vld && !o_rsp.ready;
        if (accept) begin
            n_out_vld   = 1'b1;
            n_status    = ST_OK;
            n_ret       = 1'b0;
            n_ret_entry = '0;
            if (is_deq) begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_ret       = 1'b1;
                    n_ret_entry = entry[0];
                    n_cnt       = r_cnt - CNT_W'(1);
                end
            end else if (cls_bad) begin
                n_status = ST_BADCLASS;
            end else if (full) begin
                n_status = ST_FULL;
            end else begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_out_vld <= n_out_vld;
            r_cnt     <= n_cnt;
        end
    end

    // Response payload.
    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_ret       <= n_ret;
        r_ret_entry <= n_ret_entry;
    end

    // The fill count always matches the beat on display.
    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.status    = r_status;
    assign o_rsp.out_valid = r_ret;
    assign o_rsp.out_id    = r_ret_entry.id;
    assign o_rsp.out_class = r_ret_entry.cls;
    assign o_rsp.occupancy = r_cnt;

    `SPQ_ASSERT(a_cnt_bound, (r_cnt <= CNT_W'(DEPTH)), "fill count above depth")
    `SPQ_ASSERT(a_enq_count, (ctl.enq |=> (r_cnt == $past(r_cnt) + CNT_W'(1))), "enqueue count slip")
    `SPQ_ASSERT(a_ret_ok, ((r_out_vld && r_ret) |-> (r_status == ST_OK)), "entry with bad status")
    `SPQ_ASSERT(a_ret_cls, ((r_out_vld && r_ret) |-> (32'(r_ret_entry.cls) < 32'(LEVELS))), "bad class out")
    `SPQ_ASSERT_ALWAYS(a_rst_idle, (!i_rst_n |=> (!r_out_vld && (r_cnt == '0))), "reset not idle")

endmodule

@@ dv/tb_stable_priority_queue_core.sv @@
`timescale 1ns / 1ps

module tb_stable_priority_queue_core
    import spq_pkg::*;
();

    localparam int QDEPTH      = DEPTH_DEF;
    localparam int QLEVELS     = LEVELS_DEF;
    localparam int CNT_W       = $clog2(QDEPTH + 1);
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 4;
    localparam int MAX_REPORTS = 10;

    // One response beat as the block should present it.
    typedef struct packed {
        t_status          status;
        logic             out_valid;
        logic [ID_W-1:0]  out_id;
        logic [CLS_W-1:0] out_class;
        logic [CNT_W-1:0] occupancy;
    } t_queue_rsp;

    // Scoreboard: keeps its own sorted copy of the queue and the responses still owed.
    class queue_scoreboard;
        t_entry      slots[QDEPTH];
        int unsigned fill;
        t_queue_rsp  owed_rsps[$];
        int unsigned fail_count;

        function new();
            fill       = 0;
            fail_count = 0;
        endfunction

        function int unsigned pending();
            return owed_rsps.size();
        endfunction

        function void note_failure(string what);
            if (fail_count < MAX_REPORTS) begin
                $display("[%0t] ERROR: %s", $realtime, what);
            end
            fail_count++;
        endfunction

        // Apply one accepted request to the queue copy and record the response it owes.
        function void note_request(t_opcode op, logic [ID_W-1:0] id, logic [CLS_W-1:0] cls);
            t_queue_rsp  rsp;
            int unsigned pos;
            int unsigned k;
            rsp        = '0;
            rsp.status = ST_OK;
            if (op == OP_ENQ) begin
                if (cls >= QLEVELS) begin
                    rsp.status = ST_BADCLASS;
                end else if (fill >= QDEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    // The new entry goes behind every entry of equal or higher class.
                    pos = 0;
                    while (pos < fill && slots[pos].cls >= cls) begin
                        pos++;
                    end
                    for (k = fill; k > pos; k--) begin
                        slots[k] = slots[k - 1];
                    end
                    slots[pos].cls = cls;
                    slots[pos].id  = id;
                    fill++;
                end
            end else if (fill == 0) begin
                rsp.status = ST_EMPTY;
            end else begin
                rsp.out_valid = 1'b1;
                rsp.out_id    = slots[0].id;
                rsp.out_class = slots[0].cls;
                for (k = 1; k < fill; k++) begin
                    slots[k - 1] = slots[k];
                end
                fill--;
            end
            rsp.occupancy = CNT_W'(fill);
            owed_rsps.push_back(rsp);
        endfunction

        // Compare one accepted response beat with the oldest owed response.
        function void check_response(t_queue_rsp got);
            t_queue_rsp want;
            if (owed_rsps.size() == 0) begin
                note_failure($sformatf("response with nothing owed: status=%0d valid=%0b id=%h",
                                       got.status, got.out_valid, got.out_id));
            end else begin
                want = owed_rsps.pop_front();
                if (got.status !== want.status || got.out_valid !== want.out_valid ||
                    got.out_id !== want.out_id || got.out_class !== want.out_class ||
                    got.occupancy !== want.occupancy) begin
                    note_failure($sformatf({"mismatch: expected status=%0d valid=%0b id=%h ",
                        "class=%0d occ=%0d, got status=%0d valid=%0b id=%h class=%0d occ=%0d"},
                        want.status, want.out_valid, want.out_id, want.out_class,
                        want.occupancy, got.status, got.out_valid, got.out_id,
                        got.out_class, got.occupancy));
                end
            end
        endfunction

        function void check_drained();
            if (owed_rsps.size() != 0) begin
                note_failure($sformatf("%0d responses never arrived", owed_rsps.size()));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic rsp_hold;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   cycle_count;
    event rsp_hold_go;

    queue_scoreboard sb;

    spq_req_if                     req_if ();
    spq_rsp_if #(.CNT_W(CNT_W))    rsp_if ();

    stable_priority_queue_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit in case the block hangs.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Long response hold-off, started on request and counted here.
    initial begin : rsp_hold_ctl
        rsp_hold <= 1'b0;
        forever begin
            @(rsp_hold_go);
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rsp_hold <= 1'b0;
        end
    end

    // Response side: check each accepted beat, then choose the next ready.
    initial begin : rsp_sink
        t_queue_rsp got;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                got.status    = t_status'(rsp_if.status);
                got.out_valid = rsp_if.out_valid;
                got.out_id    = rsp_if.out_id;
                got.out_class = rsp_if.out_class;
                got.occupancy = rsp_if.occupancy;
                sb.check_response(got);
            end
            rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Offer one request beat, with random idle cycles first, and wait until it is taken.
    task automatic drive_request(input t_opcode op, input logic [ID_W-1:0] id,
                                 input logic [CLS_W-1:0] cls);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.opcode        <= op;
        req_if.customer_id   <= id;
        req_if.service_class <= cls;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        sb.note_request(op, id, cls);
    endtask

    // Stop offering and wait for every owed response.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random traffic in bursts that lean toward filling, draining or neither.
    task automatic random_traffic(input int count);
        int          burst_left;
        int          enq_pct;
        t_opcode     op;
        logic [ID_W-1:0]  id;
        logic [CLS_W-1:0] cls;
        burst_left = 0;
        enq_pct    = 50;
        repeat (count) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(40, 10);
                case ($urandom_range(2))
                    0: begin
                        enq_pct = 85;
                    end
                    1: begin
                        enq_pct = 15;
                    end
                    default: begin
                        enq_pct = 50;
                    end
                endcase
            end
            burst_left--;
            op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
            case ($urandom_range(19))
                0: begin
                    id = '0;
                end
                1: begin
                    id = '1;
                end
                default: begin
                    id = $urandom;
                end
            endcase
            // Mostly legal classes, with an occasional invalid one.
            if (op == OP_ENQ && $urandom_range(99) >= 6) begin
                cls = CLS_W'($urandom_range(QLEVELS - 1));
            end else begin
                cls = CLS_W'($urandom_range(3));
            end
            drive_request(op, id, cls);
        end
    endtask

    // Main sequence: reset, directed cases, then random phases.
    initial begin : stimulus
        int k;
        sb                   = new();
        src_idle_pct         = 0;
        snk_idle_pct         = 0;
        i_rst_n              <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.opcode        <= OP_ENQ;
        req_if.customer_id   <= '0;
        req_if.service_class <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty dequeue and an invalid class on an empty queue.
        drive_request(OP_DEQ, '0, '0);
        drive_request(OP_ENQ, '1, 2'd3);

        // Fill to capacity with mixed classes and extreme ids.
        for (k = 0; k < QDEPTH; k++) begin
            drive_request(OP_ENQ, (k[0] ? 32'hFFFF_FFF0 : 32'h0) | ID_W'(k),
                          CLS_W'((k ^ (k >> 2)) % QLEVELS));
        end

        // A full queue rejects a legal enqueue; the invalid class wins over full.
        drive_request(OP_ENQ, 32'hA5A5_5A5A, 2'd2);
        drive_request(OP_ENQ, 32'h5A5A_A5A5, 2'd3);

        // Dequeues ignore the id and class fields.
        repeat (4) drive_request(OP_DEQ, '1, 2'd3);

        // Sender idles rarely, receiver holds off often.
        src_idle_pct = 19;
        snk_idle_pct = 69;
        random_traffic(260);

        // Receiver holds off while the sender keeps offering, then a full drain.
        src_idle_pct = 0;
        -> rsp_hold_go;
        random_traffic(40);
        wait_drained();

        src_idle_pct = 69;
        snk_idle_pct = 19;
        random_traffic(250);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_traffic(250);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        sb.check_drained();
        if (sb.fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/spq_pkg.sv
sv/spq_req_if.sv
sv/spq_rsp_if.sv
sv/spq_cell.sv
sv/stable_priority_queue_core.sv
dv/tb_stable_priority_queue_core.sv
